// ===== hw/rtl/mmls_pkg.sv =====
// ----------------------------------------------------------------------------
// mmls_pkg
// Shared constants and interface types for the majority merge selector.
// ----------------------------------------------------------------------------
`default_nettype none

package mmls_pkg;

  localparam int ALPHA_MAX_DEF   = 32;
  localparam int WEIGHT_BITS_DEF = 24;
  localparam int SYM_W           = 5;
  localparam int IN_WEIGHT_W     = 24;
  localparam int ALPH_W          = 6;

  localparam logic [ALPH_W-1:0] ALPH_RESET = 6'd32;

  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_HEAD   = 1'b1;

  // run: sweep one matrix entry per cycle, walk: score while sweeping
  typedef struct packed {
    logic run;
    logic walk;
  } scan_ctl_t;

  // last: final entry issued this cycle, busy: scoring pipeline not empty
  typedef struct packed {
    logic last;
    logic busy;
  } scan_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/majority_merge_lookahead_select.sv =====
// Load words are taken one per cycle while in_stall is low; a word with
//   last_item set leads through the settle state and the follow matrix ram
//   sweep to the done state, which registers the result word; in_stall stays
//   high from that word until the result word is registered
// reset: a clearing pass over every follow matrix entry zeroes both rams,
//   in_stall stays high meanwhile; alphabet size resets to 32
// ----------------------------------------------------------------------------
// majority_merge_lookahead_select
// Weighted majority merge next-symbol selector with one-symbol lookahead.
// ----------------------------------------------------------------------------
`default_nettype none

module majority_merge_lookahead_select import mmls_pkg::*; #(
  parameter int ALPHA_MAX   = ALPHA_MAX_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_cmd,
  input  wire logic [SYM_W-1:0]       in_symbol,
  input  wire logic [IN_WEIGHT_W-1:0] in_weight,
  input  wire logic                   in_has_next,
  input  wire logic [SYM_W-1:0]       in_next_symbol,
  input  wire logic                   in_last_item,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [SYM_W-1:0]       out_chosen_symbol,
  output logic                        out_found,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [ALPH_W-1:0]      cfg_alphabet_size
);

  localparam int IW  = $clog2(ALPHA_MAX);
  localparam int FD  = ALPHA_MAX * ALPHA_MAX;
  localparam int FW  = $clog2(FD);
  localparam int AW  = (WEIGHT_BITS > IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam int ADW = AW + 1;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_SETTLE = 5'b00100,
    ST_WALK   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [ALPH_W-1:0]    alph_r;
  logic [ALPHA_MAX-1:0] present_r;

  logic in_acc, finish;
  logic sym_ok, nxt_ok, op_w, op_f, mark;
  logic [IW-1:0] sym_idx, nxt_idx;
  logic [FW-1:0] f_idx;

  logic                   s1_v_r, s1_f_r;
  logic [FW-1:0]          s1_addr_r;
  logic [IN_WEIGHT_W-1:0] s1_w_r;

  logic                   fw_v_r, fw_f_r;
  logic [FW-1:0]          fw_addr_r;
  logic [WEIGHT_BITS-1:0] fw_data_r;

  logic [WEIGHT_BITS-1:0] old_val, new_val;
  logic [ADW-1:0]         sum;

  scan_ctl_t scan_ctl;
  scan_sts_t scan_sts;
  logic [IW-1:0]          sc_w_addr, sc_chosen;
  logic [FW-1:0]          sc_f_addr;
  logic                   sc_w_we, sc_f_we, sc_found;

  logic                   w_we, f_we;
  logic [IW-1:0]          w_waddr, w_raddr;
  logic [FW-1:0]          f_waddr, f_raddr;
  logic [WEIGHT_BITS-1:0] w_wdata, f_wdata, w_rdata, f_rdata;

  logic             out_valid_r, out_found_r;
  logic [SYM_W-1:0] out_sym_r;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alph_r <= ALPH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      alph_r <= cfg_alphabet_size;
    end
  end

  // load decode
  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    sym_ok  = (32'(in_symbol) < ALPHA_MAX);
    nxt_ok  = (32'(in_next_symbol) < ALPHA_MAX);
    sym_idx = IW'(in_symbol);
    nxt_idx = IW'(in_next_symbol);
    f_idx   = FW'(FW'(sym_idx) * FW'(ALPHA_MAX) + FW'(nxt_idx));
    op_w    = sym_ok && (in_cmd == CMD_WEIGHT);
    op_f    = sym_ok && (in_cmd == CMD_HEAD) && in_has_next && nxt_ok;
    mark    = sym_ok && (in_cmd == CMD_HEAD) && (!in_has_next || nxt_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      present_r <= '0;
    end else if (in_acc && mark) begin
      present_r[sym_idx] <= 1'b1;
    end
  end

  // read-modify-write stage with forwarding of the previous write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fw_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc && (op_w || op_f);
      fw_v_r <= s1_v_r;
    end
    if (in_acc) begin
      s1_f_r    <= op_f;
      s1_addr_r <= op_f ? f_idx : FW'(sym_idx);
      s1_w_r    <= in_weight;
    end
    fw_f_r    <= s1_f_r;
    fw_addr_r <= s1_addr_r;
    fw_data_r <= new_val;
  end

  always_comb begin
    if (fw_v_r && (fw_f_r == s1_f_r) && (fw_addr_r == s1_addr_r)) begin
      old_val = fw_data_r;
    end else begin
      old_val = s1_f_r ? f_rdata : w_rdata;
    end
    sum = ADW'(old_val) + ADW'(s1_w_r);
    if (sum[ADW-1:WEIGHT_BITS] != '0) begin
      new_val = '1;
    end else begin
      new_val = sum[WEIGHT_BITS-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (scan_sts.last) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (in_acc && in_last_item) state_nxt = ST_SETTLE;
      end
      ST_SETTLE: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (scan_sts.last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (finish) state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign scan_ctl.run  = (state_r == ST_CLEAR) || (state_r == ST_WALK);
  assign scan_ctl.walk = (state_r == ST_WALK);

  assign finish = (state_r == ST_DONE) && !scan_sts.busy && (!out_valid_r || !out_stall);

  mmls_scan #(
    .ALPHA_MAX   (ALPHA_MAX),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .sts       (scan_sts),
    .alph_size (alph_r),
    .present   (present_r),
    .w_addr    (sc_w_addr),
    .w_we      (sc_w_we),
    .w_rdata   (w_rdata),
    .f_addr    (sc_f_addr),
    .f_we      (sc_f_we),
    .f_rdata   (f_rdata),
    .res_clear (finish),
    .found     (sc_found),
    .chosen    (sc_chosen)
  );

  // ram port muxing
  always_comb begin
    if (scan_ctl.run) begin
      w_we    = sc_w_we;
      w_waddr = sc_w_addr;
      w_wdata = '0;
      w_raddr = sc_w_addr;
      f_we    = sc_f_we;
      f_waddr = sc_f_addr;
      f_wdata = '0;
      f_raddr = sc_f_addr;
    end else begin
      w_we    = s1_v_r && !s1_f_r;
      w_waddr = IW'(s1_addr_r);
      w_wdata = new_val;
      w_raddr = sym_idx;
      f_we    = s1_v_r && s1_f_r;
      f_waddr = s1_addr_r;
      f_wdata = new_val;
      f_raddr = f_idx;
    end
  end

  mmls_ram #(
    .DEPTH (ALPHA_MAX),
    .WIDTH (WEIGHT_BITS)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mmls_ram #(
    .DEPTH (FD),
    .WIDTH (WEIGHT_BITS)
  ) u_follow_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (finish) begin
      out_found_r <= sc_found;
      out_sym_r   <= sc_found ? SYM_W'(sc_chosen) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_chosen_symbol = out_sym_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mmls_ram.sv =====
// ----------------------------------------------------------------------------
// mmls_ram
// Simple dual port synchronous ram, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmls_ram import mmls_pkg::*; #(
  parameter int DEPTH = ALPHA_MAX_DEF,
  parameter int WIDTH = WEIGHT_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mmls_scan.sv =====
// ----------------------------------------------------------------------------
// mmls_scan
// Row by row sweep of the follow matrix: clears the stores and scores every
// present symbol below the alphabet size with its best one-symbol lookahead.
// ----------------------------------------------------------------------------
`default_nettype none

module mmls_scan import mmls_pkg::*; #(
  parameter int ALPHA_MAX   = ALPHA_MAX_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  localparam int IW         = $clog2(ALPHA_MAX),
  localparam int FW         = $clog2(ALPHA_MAX * ALPHA_MAX)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire scan_ctl_t              ctl,
  output scan_sts_t                   sts,
  input  wire logic [ALPH_W-1:0]      alph_size,
  input  wire logic [ALPHA_MAX-1:0]   present,
  output logic      [IW-1:0]          w_addr,
  output logic                        w_we,
  input  wire logic [WEIGHT_BITS-1:0] w_rdata,
  output logic      [FW-1:0]          f_addr,
  output logic                        f_we,
  input  wire logic [WEIGHT_BITS-1:0] f_rdata,
  input  wire logic                   res_clear,
  output logic                        found,
  output logic      [IW-1:0]          chosen
);

  localparam int TW = WEIGHT_BITS + 1;
  localparam int SW = WEIGHT_BITS + 2;

  logic [IW-1:0] i_r, j_r;
  logic [FW-1:0] a_r;
  logic          i_last, j_last;

  logic          p1_v_r;
  logic [IW-1:0] p1_i_r, p1_j_r;

  logic [TW-1:0]          bonus_r;
  logic [WEIGHT_BITS-1:0] wi_r;

  logic                   row_v_r, row_cand_r;
  logic [IW-1:0]          row_i_r;
  logic [TW-1:0]          row_bonus_r;
  logic [WEIGHT_BITS-1:0] row_wi_r;

  logic [SW-1:0] best_r;
  logic          found_r;
  logic [IW-1:0] chosen_r;

  logic [WEIGHT_BITS-1:0] t_w, wi_nxt;
  logic [TW-1:0]          t_sum, t_use, bonus_base, bonus_nxt;
  logic                   col_in, row_end, diag;
  logic [SW-1:0]          score;

  assign i_last = (32'(i_r) == ALPHA_MAX - 1);
  assign j_last = (32'(j_r) == ALPHA_MAX - 1);

  assign w_addr = j_r;
  assign f_addr = a_r;
  assign f_we   = ctl.run;
  // during a walk weights are read by every row, so they clear on the final row only
  assign w_we   = ctl.run && (!ctl.walk || i_last);

  assign sts.last = ctl.run && i_last && j_last;
  assign sts.busy = p1_v_r || row_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
      a_r <= '0;
    end else if (ctl.run) begin
      if (j_last) begin
        j_r <= '0;
        i_r <= i_last ? '0 : i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
      a_r <= (i_last && j_last) ? '0 : a_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= ctl.run && ctl.walk;
    end
    p1_i_r <= i_r;
    p1_j_r <= j_r;
  end

  always_comb begin
    diag       = (p1_j_r == p1_i_r);
    t_w        = diag ? '0 : w_rdata;
    t_sum      = TW'(t_w) + TW'(f_rdata);
    col_in     = (32'(p1_j_r) < 32'(alph_size));
    t_use      = col_in ? t_sum : '0;
    bonus_base = (p1_j_r == '0) ? '0 : bonus_r;
    bonus_nxt  = (t_use > bonus_base) ? t_use : bonus_base;
    wi_nxt     = diag ? w_rdata : wi_r;
    row_end    = (32'(p1_j_r) == ALPHA_MAX - 1);
  end

  always_ff @(posedge clk) begin
    if (p1_v_r) begin
      bonus_r <= bonus_nxt;
      wi_r    <= wi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_v_r <= 1'b0;
    end else begin
      row_v_r <= p1_v_r && row_end;
    end
    if (p1_v_r && row_end) begin
      row_i_r     <= p1_i_r;
      row_bonus_r <= bonus_nxt;
      row_wi_r    <= wi_nxt;
      row_cand_r  <= present[p1_i_r] && (32'(p1_i_r) < 32'(alph_size));
    end
  end

  assign score = SW'(row_wi_r) + SW'(row_bonus_r);

  always_ff @(posedge clk) begin
    if (!rst_n || res_clear) begin
      best_r   <= '0;
      found_r  <= 1'b0;
      chosen_r <= '0;
    end else if (row_v_r && row_cand_r && (score > best_r)) begin
      best_r   <= score;
      found_r  <= 1'b1;
      chosen_r <= row_i_r;
    end
  end

  assign found  = found_r;
  assign chosen = chosen_r;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the majority merge lookahead selector: weight and
// sequence-head words are streamed in with random gaps and back-pressure, an
// internal scoreboard tracks the symbol and follow tables and scores each
// selection, and every result word is compared against the predicted pick.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import mmls_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSYM          = ALPHA_MAX_DEF;
  localparam int WBITS         = WEIGHT_BITS_DEF;
  localparam int SWEEP_CYCLES  = NSYM * NSYM + 4;
  localparam int SETTLE_CYCLES = SWEEP_CYCLES + 32;
  localparam int LONG_HOLD     = 3 * SWEEP_CYCLES;
  localparam logic [WBITS-1:0] W_FULL = '1;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             found;
  } pick_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_cmd = CMD_WEIGHT;
  logic [SYM_W-1:0]       in_symbol = '0;
  logic [IN_WEIGHT_W-1:0] in_weight = '0;
  logic                   in_has_next = 1'b0;
  logic [SYM_W-1:0]       in_next_symbol = '0;
  logic                   in_last_item = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SYM_W-1:0]       out_chosen_symbol;
  logic                   out_found;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [ALPH_W-1:0]      cfg_alphabet_size = ALPH_RESET;

  majority_merge_lookahead_select dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_symbol         (in_symbol),
    .in_weight         (in_weight),
    .in_has_next       (in_has_next),
    .in_next_symbol    (in_next_symbol),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_chosen_symbol (out_chosen_symbol),
    .out_found         (out_found),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_alphabet_size (cfg_alphabet_size)
  );

  logic [WBITS-1:0]  sym_wt    [NSYM];
  logic              sym_seen  [NSYM];
  logic [WBITS-1:0]  follow_wt [NSYM][NSYM];
  logic [ALPH_W-1:0] alpha_reg = ALPH_RESET;
  pick_t             pending_picks [$];
  int                mismatches = 0;
  int                tx_quiet = 0;
  int                rx_quiet = 0;
  int                rx_hold = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("majority_merge_lookahead_select test failed");
    $finish;
  end

  function automatic logic [WBITS-1:0] sat_add(logic [WBITS-1:0] a,
                                               logic [IN_WEIGHT_W-1:0] b);
    logic [WBITS:0] s;
    s = a + b;
    return (s > W_FULL) ? W_FULL : s[WBITS-1:0];
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i < NSYM; i++) begin
      sym_wt[i]   = '0;
      sym_seen[i] = 1'b0;
      for (int j = 0; j < NSYM; j++) follow_wt[i][j] = '0;
    end
  endfunction

  function automatic pick_t pick_next_symbol();
    int              used;
    longint unsigned best, bonus, t, score;
    pick_t           r;
    used = (alpha_reg > NSYM) ? NSYM : int'(alpha_reg);
    best = 0;
    r    = '0;
    for (int i = 0; i < used; i++) begin
      if (sym_seen[i]) begin
        bonus = 0;
        for (int j = 0; j < used; j++) begin
          t = ((j == i) ? 64'd0 : 64'(sym_wt[j])) + 64'(follow_wt[i][j]);
          if (t > bonus) bonus = t;
        end
        score = 64'(sym_wt[i]) + bonus;
        if (score > best) begin
          best    = score;
          r.sym   = SYM_W'(i);
          r.found = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic void absorb_word(logic cmd, logic [SYM_W-1:0] sym,
                                      logic [IN_WEIGHT_W-1:0] w, logic hn,
                                      logic [SYM_W-1:0] nxt, logic last);
    if (cmd == CMD_WEIGHT) begin
      sym_wt[sym] = sat_add(sym_wt[sym], w);
    end else if (!hn) begin
      sym_seen[sym] = 1'b1;
    end else begin
      sym_seen[sym]       = 1'b1;
      follow_wt[sym][nxt] = sat_add(follow_wt[sym][nxt], w);
    end
    if (last) begin
      pending_picks.push_back(pick_next_symbol());
      clear_tables();
    end
  endfunction

  always @(posedge clk) begin : check_results
    pick_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with no pick pending: sym %0d found %0b",
                   $realtime, out_chosen_symbol, out_found);
      end else begin
        want = pending_picks.pop_front();
        if (out_chosen_symbol !== want.sym || out_found !== want.found) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: pick mismatch: sym exp %0d got %0d, found exp %0b got %0b",
                     $realtime, want.sym, out_chosen_symbol, want.found, out_found);
        end
      end
    end
  end

  // result side back-pressure, long holds counted here
  initial begin : result_sink
    int stall_for;
    forever begin
      stall_for = rx_quiet ? 0 : $urandom_range(0, 13);
      if (rx_hold > 0) begin
        stall_for = rx_hold;
        rx_hold   = 0;
      end
      if (stall_for > 0) begin
        out_stall <= 1'b1;
        repeat (stall_for) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && rx_hold == 0);
    end
  end

  task automatic send_word(logic cmd, logic [SYM_W-1:0] sym,
                           logic [IN_WEIGHT_W-1:0] w, logic hn,
                           logic [SYM_W-1:0] nxt, logic last);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_symbol      <= sym;
    in_weight      <= w;
    in_has_next    <= hn;
    in_next_symbol <= nxt;
    in_last_item   <= last;
    do @(posedge clk); while (in_stall);
    absorb_word(cmd, sym, w, hn, nxt, last);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_picks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_alphabet(logic [ALPH_W-1:0] v);
    cfg_valid         <= 1'b1;
    cfg_alphabet_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    alpha_reg = v;
  endtask

  function automatic logic [SYM_W-1:0] rand_sym(int span);
    if ($urandom_range(0, 7) == 0) return SYM_W'($urandom_range(0, NSYM - 1));
    return SYM_W'($urandom_range(0, span - 1));
  endfunction

  function automatic logic [IN_WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return IN_WEIGHT_W'($urandom_range(24'hFFF000, 24'hFFFFFF));
      3, 4:    return IN_WEIGHT_W'($urandom_range(0, 15));
      default: return IN_WEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic send_group(int len, int span);
    logic                   cmd, hn;
    logic [SYM_W-1:0]       sym, nxt;
    logic [IN_WEIGHT_W-1:0] w;
    for (int k = 0; k < len; k++) begin
      cmd = ($urandom_range(0, 9) < 4) ? CMD_WEIGHT : CMD_HEAD;
      sym = rand_sym(span);
      nxt = rand_sym(span);
      hn  = ($urandom_range(0, 4) != 0);
      w   = rand_weight();
      send_word(cmd, sym, w, hn, nxt, k == len - 1);
    end
  endtask

  task automatic test_directed_scoring();
    // lone head with zero score
    send_word(CMD_HEAD, 5'd5, '1, 1'b0, 5'd31, 1'b1);
    // saturating weights and follow entries, top symbol
    send_word(CMD_WEIGHT, 5'd31, '1, 1'b0, 5'd0, 1'b0);
    send_word(CMD_WEIGHT, 5'd31, '1, 1'b1, 5'd31, 1'b0);
    send_word(CMD_HEAD, 5'd31, 24'd1234, 1'b0, 5'd7, 1'b0);
    send_word(CMD_HEAD, 5'd0, '1, 1'b1, 5'd31, 1'b0);
    send_word(CMD_HEAD, 5'd0, 24'd1, 1'b1, 5'd31, 1'b0);
    send_word(CMD_WEIGHT, 5'd0, '0, 1'b0, 5'd0, 1'b1);
    // tie goes to the lower index
    send_word(CMD_WEIGHT, 5'd3, 24'd10, 1'b0, 5'd0, 1'b0);
    send_word(CMD_WEIGHT, 5'd7, 24'd10, 1'b0, 5'd0, 1'b0);
    send_word(CMD_HEAD, 5'd7, 24'd0, 1'b0, 5'd0, 1'b0);
    send_word(CMD_HEAD, 5'd3, 24'd0, 1'b0, 5'd0, 1'b1);
    // follow to itself drops the own weight term
    send_word(CMD_HEAD, 5'd2, 24'd5, 1'b1, 5'd2, 1'b0);
    send_word(CMD_WEIGHT, 5'd2, 24'd1, 1'b0, 5'd0, 1'b1);
    drain_results();
  endtask

  task automatic test_alphabet_limits();
    logic [ALPH_W-1:0] sizes [3];
    sizes = '{6'd1, 6'd0, 6'd63};
    for (int s = 0; s < 3; s++) begin
      write_alphabet(sizes[s]);
      send_word(CMD_WEIGHT, 5'd0, 24'd2, 1'b0, 5'd0, 1'b0);
      send_word(CMD_HEAD, 5'd0, 24'd7, 1'b1, 5'd1, 1'b0);
      send_word(CMD_WEIGHT, 5'd31, 24'd5, 1'b0, 5'd0, 1'b0);
      send_word(CMD_HEAD, 5'd31, 24'd1, 1'b1, 5'd0, 1'b1);
      drain_results();
    end
    write_alphabet(ALPH_RESET);
  endtask

  task automatic test_backpressure();
    rx_hold  = LONG_HOLD;
    tx_quiet = 1;
    repeat (3) send_group($urandom_range(4, 8), NSYM);
    tx_quiet = 0;
    // sender pauses until every pick is out
    drain_results();
    send_group($urandom_range(4, 8), NSYM);
    drain_results();
  endtask

  task automatic test_random_phases();
    logic [ALPH_W-1:0] sz;
    int                span, sent, len;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       sz = ALPH_RESET;
        1:       sz = 6'd1;
        2:       sz = 6'd63;
        3:       sz = 6'd0;
        4:       sz = 6'd2;
        default: sz = ALPH_W'($urandom_range(0, 63));
      endcase
      write_alphabet(sz);
      if (sz == 0) span = 8;
      else if (sz >= NSYM) span = NSYM;
      else span = int'(sz) + 1;
      tx_quiet = (p % 3 == 1);
      rx_quiet = (p % 3 == 2);
      sent = 0;
      while (sent < 94) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        send_group(len, span);
        sent += len;
      end
      tx_quiet = 0;
      rx_quiet = 0;
      drain_results();
    end
  endtask

  initial begin
    clear_tables();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_scoring();
    test_alphabet_limits();
    test_backpressure();
    test_random_phases();
    drain_results();
    if (mismatches == 0) begin
      $display("majority_merge_lookahead_select test passed");
    end else begin
      $display("majority_merge_lookahead_select test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/mmls_pkg.sv
hw/rtl/mmls_ram.sv
hw/rtl/mmls_scan.sv
hw/rtl/majority_merge_lookahead_select.sv
sim/tb.sv
